>>> rtl/wat_pkg.sv
// Shared types and constants of the weekly alarm table matcher.
package wat_pkg;

  // Command codes carried in the cmd field of an input item.
  localparam logic [1:0] CmdTick  = 2'd0;
  localparam logic [1:0] CmdEntry = 2'd1;
  localparam logic [1:0] CmdCount = 2'd2;

  // Configuration register indexes (byte address bit 2 selects the register).
  localparam logic RegActiveLines = 1'b0;

  localparam logic [11:0] ValidYear  = 12'd2024;
  localparam int          MinPerHour = 60;
  localparam int          MinPerDay  = 24 * MinPerHour;
  localparam int          KeyW       = 20;
  localparam logic [KeyW-1:0] KeyReset = {KeyW{1'b1}};
  localparam int          MaxResults = 32;
  localparam int          ResCntW    = $clog2(MaxResults + 1);

  typedef struct packed {
    logic [1:0]  cmd;
    logic [2:0]  line_sel;
    logic [1:0]  slot_sel;
    logic [2:0]  count_value;
    logic        entry_enable;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [6:0]  weekday_mask;
    logic [16:0] duration;
    logic [11:0] year;
    logic [8:0]  day_of_year;
    logic [2:0]  weekday;
  } in_t;

  typedef struct packed {
    logic [2:0]  line_id;
    logic [16:0] run_seconds;
    logic        last_event;
  } out_t;

  // One alarm entry as stored in the table memory.
  typedef struct packed {
    logic        enable;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [6:0]  weekday_mask;
    logic [16:0] duration;
  } entry_t;

  typedef enum logic [1:0] {
    OpEntry = 2'd0,
    OpCount = 2'd1,
    OpScan  = 2'd2
  } op_kind_e;

  // Operation handed from the front end to the back end. For a scan the
  // entry's hour and minute hold the tick's time.
  typedef struct packed {
    op_kind_e   kind;
    logic [2:0] line;
    logic [1:0] slot;
    logic [3:0] count;
    entry_t     entry;
    logic [2:0] weekday;
  } op_t;

  typedef enum logic [2:0] {
    BackIdle  = 3'b001,
    BackScan  = 3'b010,
    BackFlush = 3'b100
  } back_state_e;

  typedef struct packed {
    logic               idle;
    logic [ResCntW-1:0] res_cnt;
  } back_st_t;

endpackage

>>> rtl/wat_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic                                 re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/wat_front.sv
// Front end: accepts input items, drops those that do nothing and queues the rest.
module wat_front #(
  parameter int MAX_LINES      = 8,
  parameter int SLOTS_PER_LINE = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  wat_pkg::in_t in_data_i,
  output logic         push_o,
  output wat_pkg::op_t op_o,
  input  logic         full_i
);
  import wat_pkg::*;

  logic [KeyW-1:0] last_key_q, last_key_d;
  logic [KeyW-1:0] key;
  logic            accept;
  logic            line_ok, slot_ok;
  logic [3:0]      count_sat;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;

  assign key = KeyW'(32'(in_data_i.day_of_year) * MinPerDay
                     + 32'(in_data_i.hour) * MinPerHour + 32'(in_data_i.minute));

  assign line_ok   = 32'(in_data_i.line_sel) < MAX_LINES;
  assign slot_ok   = 32'(in_data_i.slot_sel) < SLOTS_PER_LINE;
  assign count_sat = (32'(in_data_i.count_value) > SLOTS_PER_LINE) ?
                     4'(SLOTS_PER_LINE) : {1'b0, in_data_i.count_value};

  always_comb begin
    push_o             = 1'b0;
    last_key_d         = last_key_q;
    op_o.kind          = OpScan;
    op_o.line          = in_data_i.line_sel;
    op_o.slot          = in_data_i.slot_sel;
    op_o.count         = count_sat;
    op_o.entry.enable  = in_data_i.entry_enable;
    op_o.entry.hour    = in_data_i.hour;
    op_o.entry.minute  = in_data_i.minute;
    op_o.entry.weekday_mask = in_data_i.weekday_mask;
    op_o.entry.duration     = in_data_i.duration;
    op_o.weekday       = in_data_i.weekday;
    if (accept) begin
      unique case (in_data_i.cmd)
        CmdEntry: begin
          op_o.kind = OpEntry;
          push_o    = line_ok && slot_ok;
        end
        CmdCount: begin
          op_o.kind = OpCount;
          push_o    = line_ok;
        end
        CmdTick: begin
          // A tick runs a scan only once per new minute and only on a set clock.
          if (in_data_i.year >= ValidYear && key != last_key_q) begin
            op_o.kind  = OpScan;
            push_o     = 1'b1;
            last_key_d = key;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_key_q <= KeyReset;
    end else begin
      last_key_q <= last_key_d;
    end
  end

endmodule

>>> rtl/wat_queue.sv
// Short operation queue between the front end and the back end.
module wat_queue #(
  parameter int DEPTH = 2
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  wat_pkg::op_t                   op_i,
  output logic                           full_o,
  input  logic                           pop_i,
  output logic                           valid_o,
  output wat_pkg::op_t                   op_o,
  output logic [$clog2(DEPTH + 1)-1:0]   level_o
);
  import wat_pkg::*;

  localparam int PW = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH + 1);

  op_t           slots_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [LW-1:0] level_q;
  logic          do_push, do_pop;

  assign full_o  = level_q == LW'(DEPTH);
  assign valid_o = level_q != '0;
  assign op_o    = slots_q[rd_ptr_q];
  assign level_o = level_q;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        level_q <= level_q + LW'(1);
      end else if (do_pop && !do_push) begin
        level_q <= level_q - LW'(1);
      end
    end
  end

endmodule

>>> rtl/wat_back.sv
// Back end: applies table writes and scans the table for each new minute.
module wat_back #(
  parameter int MAX_LINES      = 8,
  parameter int SLOTS_PER_LINE = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [3:0]        active_lines_i,
  input  logic              q_valid_i,
  input  wat_pkg::op_t      q_op_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output wat_pkg::out_t     out_data_o,
  output wat_pkg::back_st_t status_o
);
  import wat_pkg::*;

  localparam int Entries = MAX_LINES * SLOTS_PER_LINE;
  localparam int AW      = Entries > 1 ? $clog2(Entries) : 1;
  localparam int LW      = $clog2(MAX_LINES + 1);
  localparam int LIW     = MAX_LINES > 1 ? $clog2(MAX_LINES) : 1;
  localparam int SW      = $clog2(SLOTS_PER_LINE + 1);
  localparam int EW      = $bits(entry_t);

  back_state_e        state_q, state_d;
  logic [LW-1:0]      lines_q, lines_d, gen_l_q, gen_l_d, lines_sat;
  logic [SW-1:0]      gen_s_q, gen_s_d, cur_cnt;
  logic [AW-1:0]      base_q, base_d, rd_addr, wr_addr;
  logic [4:0]         t_hour_q, t_hour_d;
  logic [5:0]         t_min_q, t_min_d;
  logic [2:0]         t_wday_q, t_wday_d;
  logic               cmp_valid_q, cmp_valid_d, cmp_vld_q, cmp_vld_d;
  logic [2:0]         cmp_line_q, cmp_line_d;
  logic               held_valid_q, held_valid_d;
  out_t               held_q, held_d, out_q, load_data;
  logic               out_valid_q, load_out;
  logic [ResCntW-1:0] res_cnt_q, res_cnt_d;
  logic [SW-1:0]      cnt_q [MAX_LINES];
  logic [Entries-1:0] vld_q;
  logic [LIW-1:0]     cnt_idx;
  logic               cnt_we, vld_we, ram_re;
  logic [EW-1:0]      ram_rdata;
  entry_t             cmp_entry;
  logic               gen_busy, issue, s_more, match, out_free, hit_stall;
  logic [7:0]         mask_ext;

  wat_ram #(
    .WIDTH(EW),
    .DEPTH(Entries)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (vld_we),
    .waddr_i(wr_addr),
    .wdata_i(q_op_i.entry),
    .re_i   (ram_re),
    .raddr_i(rd_addr),
    .rdata_o(ram_rdata)
  );

  assign cmp_entry = entry_t'(ram_rdata);
  assign wr_addr   = AW'(32'(q_op_i.line) * SLOTS_PER_LINE + 32'(q_op_i.slot));
  assign cnt_idx   = LIW'(q_op_i.line);
  assign lines_sat = (32'(active_lines_i) > MAX_LINES) ? LW'(MAX_LINES) : LW'(active_lines_i);

  // Slot generator: walks line by line, one used slot per cycle while no result
  // stall holds it, and skips an empty line without reading it.
  assign gen_busy = gen_l_q < lines_q;
  assign cur_cnt  = gen_busy ? cnt_q[gen_l_q[LIW-1:0]] : '0;
  assign rd_addr  = base_q + AW'(gen_s_q);
  assign issue    = gen_busy && (gen_s_q < cur_cnt);
  assign s_more   = ({1'b0, gen_s_q} + 1'b1) < {1'b0, cur_cnt};

  // Compare stage works on the registered RAM output; weekday 7 has no mask bit.
  assign mask_ext = {1'b0, cmp_entry.weekday_mask};
  assign match    = cmp_valid_q && cmp_vld_q && cmp_entry.enable
                    && cmp_entry.hour == t_hour_q && cmp_entry.minute == t_min_q
                    && mask_ext[t_wday_q] && (res_cnt_q < ResCntW'(MaxResults));

  assign out_free  = !out_valid_q || out_ready_i;
  // A new match must push the held one out; it waits while the output is full.
  assign hit_stall = match && held_valid_q && !out_free;

  always_comb begin
    state_d      = state_q;
    lines_d      = lines_q;
    gen_l_d      = gen_l_q;
    gen_s_d      = gen_s_q;
    base_d       = base_q;
    t_hour_d     = t_hour_q;
    t_min_d      = t_min_q;
    t_wday_d     = t_wday_q;
    cmp_valid_d  = cmp_valid_q;
    cmp_vld_d    = cmp_vld_q;
    cmp_line_d   = cmp_line_q;
    held_valid_d = held_valid_q;
    held_d       = held_q;
    res_cnt_d    = res_cnt_q;
    load_out     = 1'b0;
    load_data    = held_q;
    q_pop_o      = 1'b0;
    cnt_we       = 1'b0;
    vld_we       = 1'b0;
    ram_re       = 1'b0;
    unique case (state_q)
      BackIdle: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          unique case (q_op_i.kind)
            OpEntry: vld_we = 1'b1;
            OpCount: cnt_we = 1'b1;
            OpScan: begin
              lines_d     = lines_sat;
              gen_l_d     = '0;
              gen_s_d     = '0;
              base_d      = '0;
              t_hour_d    = q_op_i.entry.hour;
              t_min_d     = q_op_i.entry.minute;
              t_wday_d    = q_op_i.weekday;
              cmp_valid_d = 1'b0;
              res_cnt_d   = '0;
              state_d     = BackScan;
            end
            default: ;
          endcase
        end
      end
      BackScan: begin
        if (!hit_stall) begin
          cmp_valid_d = issue;
          if (issue) begin
            ram_re     = 1'b1;
            cmp_vld_d  = vld_q[rd_addr];
            cmp_line_d = 3'(gen_l_q);
          end
          if (gen_busy) begin
            if (issue && s_more) begin
              gen_s_d = gen_s_q + SW'(1);
            end else begin
              gen_l_d = gen_l_q + LW'(1);
              gen_s_d = '0;
              base_d  = base_q + AW'(SLOTS_PER_LINE);
            end
          end
          if (match) begin
            // The held result is not the last one, so it leaves unmarked.
            if (held_valid_q) begin
              load_out = 1'b1;
            end
            held_d.line_id     = cmp_line_q;
            held_d.run_seconds = cmp_entry.duration;
            held_d.last_event  = 1'b0;
            held_valid_d       = 1'b1;
            res_cnt_d          = res_cnt_q + ResCntW'(1);
          end
        end
        if (!gen_busy && !cmp_valid_q) begin
          state_d = BackFlush;
        end
      end
      BackFlush: begin
        if (!held_valid_q) begin
          state_d = BackIdle;
        end else if (out_free) begin
          load_out             = 1'b1;
          load_data.last_event = 1'b1;
          held_valid_d         = 1'b0;
          state_d              = BackIdle;
        end
      end
      default: state_d = BackIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= BackIdle;
      lines_q      <= '0;
      gen_l_q      <= '0;
      gen_s_q      <= '0;
      base_q       <= '0;
      cmp_valid_q  <= 1'b0;
      held_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      res_cnt_q    <= '0;
      vld_q        <= '0;
      for (int i = 0; i < MAX_LINES; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      state_q      <= state_d;
      lines_q      <= lines_d;
      gen_l_q      <= gen_l_d;
      gen_s_q      <= gen_s_d;
      base_q       <= base_d;
      cmp_valid_q  <= cmp_valid_d;
      held_valid_q <= held_valid_d;
      out_valid_q  <= load_out || (out_valid_q && !out_ready_i);
      res_cnt_q    <= res_cnt_d;
      if (vld_we) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (cnt_we) begin
        cnt_q[cnt_idx] <= SW'(q_op_i.count);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    t_hour_q   <= t_hour_d;
    t_min_q    <= t_min_d;
    t_wday_q   <= t_wday_d;
    cmp_vld_q  <= cmp_vld_d;
    cmp_line_q <= cmp_line_d;
    held_q     <= held_d;
    if (load_out) begin
      out_q <= load_data;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_data_o       = out_q;
  assign status_o.idle    = state_q == BackIdle;
  assign status_o.res_cnt = res_cnt_q;

endmodule

>>> rtl/weekly_alarm_table_matcher_core.sv
// Top level of the weekly alarm table matcher: front end, queue, back end, register port.
//
// The block holds MAX_LINES x SLOTS_PER_LINE alarm entries in a RAM and a slot
// count per line. The front end takes one item per cycle while its two-entry
// operation queue has room; it drops unknown commands, out-of-range writes and
// ticks with a year before 2024 or a repeated minute. The back end applies an
// entry or count write as it pops it. A scanning tick reads the table one entry
// per cycle through the RAM's single read port while the result output does not
// stall it; the back end pops no new operation until the scan has finished.
// The final start event of a tick carries last_event; a tick with no match gives
// no transfer. Register active_lines sits at byte address 0; the user must write
// it only while the block is idle, and the block itself does not enforce this.
module weekly_alarm_table_matcher_core #(
  parameter int MAX_LINES      = 8,
  parameter int SLOTS_PER_LINE = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  wat_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output wat_pkg::out_t out_data_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import wat_pkg::*;

  localparam int QueueDepth = 2;
  localparam int QLW        = $clog2(QueueDepth + 1);

  logic           push, q_full, q_valid, q_pop;
  op_t            front_op, q_op;
  logic [QLW-1:0] q_level;
  back_st_t       back_st;
  logic [3:0]     active_lines_q;
  logic           cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == RegActiveLines) ? {28'd0, active_lines_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_lines_q <= '0;
    end else if (cfg_wr && paddr[2] == RegActiveLines) begin
      active_lines_q <= pwdata[3:0];
    end
  end

  wat_front #(
    .MAX_LINES     (MAX_LINES),
    .SLOTS_PER_LINE(SLOTS_PER_LINE)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i (in_data_i),
    .push_o    (push),
    .op_o      (front_op),
    .full_i    (q_full)
  );

  wat_queue #(
    .DEPTH(QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .op_i   (front_op),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .op_o   (q_op),
    .level_o(q_level)
  );

  wat_back #(
    .MAX_LINES     (MAX_LINES),
    .SLOTS_PER_LINE(SLOTS_PER_LINE)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .active_lines_i(active_lines_q),
    .q_valid_i     (q_valid),
    .q_op_i        (q_op),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_o    (out_data_o),
    .status_o      (back_st)
  );

  // A tick never emits more start events than the result cap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_st.res_cnt <= ResCntW'(MaxResults))
    else $error("result count exceeds cap");

  // An unmarked event always has a later event of the same tick behind it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.last_event) |-> !back_st.idle)
    else $error("unmarked event with back end idle");

  // The queue never holds more operations than it has entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_level <= QLW'(QueueDepth))
    else $error("queue level overflow");

  // A popped operation always comes from a non-empty queue and only while the back end is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> (q_valid && back_st.idle))
    else $error("pop from empty queue or busy back end");

endmodule

>>> tb/wat_start_event_checker.sv
// Checker of the alarm matcher: tracks the table, predicts start events and compares them.
`timescale 1ns / 100ps

module wat_start_event_checker #(
  parameter int MaxLines     = 8,
  parameter int SlotsPerLine = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_ready_i,
  input  wat_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_ready_i,
  input  wat_pkg::out_t out_data_i,
  input  logic          psel_i,
  input  logic          penable_i,
  input  logic          pwrite_i,
  input  logic [2:0]    paddr_i,
  input  logic [31:0]   pwdata_i,
  input  logic          pready_i,
  output int            mismatch_count_o,
  output int            pending_count_o
);
  import wat_pkg::*;

  entry_t          alarm_mem [MaxLines][SlotsPerLine];
  logic [2:0]      used_slots [MaxLines];
  logic [KeyW-1:0] minute_key_seen;
  logic [3:0]      scan_lines;
  out_t            start_events_due [$];
  int              mismatches = 0;

  // Updates the table copy and queues the start events that one transfer causes.
  task automatic apply_item(input in_t item);
    logic [KeyW-1:0] key;
    logic [7:0]      day_bit;
    entry_t          slot_entry;
    out_t            ev;
    int              lines;
    int              hits;

    case (item.cmd)
      CmdEntry: begin
        if (item.line_sel < MaxLines && item.slot_sel < SlotsPerLine) begin
          slot_entry.enable       = item.entry_enable;
          slot_entry.hour         = item.hour;
          slot_entry.minute       = item.minute;
          slot_entry.weekday_mask = item.weekday_mask;
          slot_entry.duration     = item.duration;
          alarm_mem[item.line_sel][item.slot_sel] = slot_entry;
        end
      end
      CmdCount: begin
        if (item.line_sel < MaxLines) begin
          used_slots[item.line_sel] = (item.count_value > SlotsPerLine) ?
                                      3'(SlotsPerLine) : item.count_value;
        end
      end
      CmdTick: begin
        key = KeyW'(item.day_of_year * MinPerDay + item.hour * MinPerHour + item.minute);
        if (item.year >= ValidYear && key != minute_key_seen) begin
          minute_key_seen = key;
          // Weekday 7 shifts past the mask, so such a tick matches nothing.
          day_bit = 8'd1 << item.weekday;
          lines = (scan_lines > MaxLines) ? MaxLines : int'(scan_lines);
          hits = 0;
          for (int l = 0; l < lines; l++) begin
            for (int s = 0; s < used_slots[l]; s++) begin
              slot_entry = alarm_mem[l][s];
              if (slot_entry.enable && slot_entry.hour == item.hour &&
                  slot_entry.minute == item.minute &&
                  ({1'b0, slot_entry.weekday_mask} & day_bit) != 8'd0 && hits < MaxResults) begin
                ev.line_id     = 3'(l);
                ev.run_seconds = slot_entry.duration;
                ev.last_event  = 1'b0;
                start_events_due.push_back(ev);
                hits++;
              end
            end
          end
          if (hits > 0) begin
            ev = start_events_due.pop_back();
            ev.last_event = 1'b1;
            start_events_due.push_back(ev);
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_start_event(input out_t got);
    out_t want;

    if (start_events_due.size() == 0) begin
      $error("unexpected start event: line_id %0d run_seconds %0d last_event %0d",
             got.line_id, got.run_seconds, got.last_event);
      mismatches++;
    end else begin
      want = start_events_due.pop_front();
      if (got.line_id !== want.line_id) begin
        $error("line_id: expected %0d, got %0d", want.line_id, got.line_id);
        mismatches++;
      end
      if (got.run_seconds !== want.run_seconds) begin
        $error("run_seconds: expected %0d, got %0d", want.run_seconds, got.run_seconds);
        mismatches++;
      end
      if (got.last_event !== want.last_event) begin
        $error("last_event: expected %0d, got %0d", want.last_event, got.last_event);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < MaxLines; l++) begin
        used_slots[l] = '0;
        for (int s = 0; s < SlotsPerLine; s++) begin
          alarm_mem[l][s] = '0;
        end
      end
      minute_key_seen = KeyReset;
      scan_lines = '0;
      start_events_due.delete();
      pending_count_o <= 0;
    end else begin
      // Results always trail their tick, so checking before predicting is safe.
      if (out_valid_i && out_ready_i) begin
        check_start_event(out_data_i);
      end
      if (in_valid_i && in_ready_i) begin
        apply_item(in_data_i);
      end
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i[2] == RegActiveLines) begin
        scan_lines = pwdata_i[3:0];
      end
      pending_count_o  <= start_events_due.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

>>> tb/weekly_alarm_table_matcher_core_test.sv
// Test top of the alarm matcher: clock, reset, stimulus, register writes and verdict.
`timescale 1ns / 100ps

module weekly_alarm_table_matcher_core_test;
  import wat_pkg::*;

  localparam int LineCount    = 8;
  localparam int SlotCount    = 4;
  localparam int CycleLimit   = 1000000;
  localparam int SettleCycles = 200;
  localparam logic [1:0] CmdUnused = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int error_count;
  int events_pending;
  int cycle_count = 0;

  int   burst_left = 0;
  bit   valid_up = 1'b0;
  int   ready_run_left = 0;
  int   ready_mode = 0;
  in_t  last_tick = '0;
  bit   have_tick = 1'b0;
  logic [4:0] pool_hour [4];
  logic [5:0] pool_minute [4];

  weekly_alarm_table_matcher_core #(
    .MAX_LINES     (LineCount),
    .SLOTS_PER_LINE(SlotCount)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  wat_start_event_checker #(
    .MaxLines    (LineCount),
    .SlotsPerLine(SlotCount)
  ) i_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .in_data_i       (in_data),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .out_data_i      (out_data),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .pready_i        (pready),
    .mismatch_count_o(error_count),
    .pending_count_o (events_pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("weekly_alarm_table_matcher_core_test: done, errors");
      $finish;
    end
  end

  // The receiver alternates between always ready, random stalls and long stalls.
  always @(posedge clk) begin
    if (ready_run_left == 0) begin
      ready_mode = $urandom_range(0, 2);
      ready_run_left = $urandom_range(8, 60);
    end
    ready_run_left--;
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  function automatic in_t make_tick(input int year, input int yday, input int hh,
                                    input int mm, input int wday);
    in_t it;

    it = '0;
    it.cmd = CmdTick;
    it.year = 12'(year);
    it.day_of_year = 9'(yday);
    it.hour = 5'(hh);
    it.minute = 6'(mm);
    it.weekday = 3'(wday);
    return it;
  endfunction

  function automatic in_t make_entry(input int line, input int slot, input bit en, input int hh,
                                     input int mm, input logic [6:0] mask, input int secs);
    in_t it;

    it = '0;
    it.cmd = CmdEntry;
    it.line_sel = 3'(line);
    it.slot_sel = 2'(slot);
    it.entry_enable = en;
    it.hour = 5'(hh);
    it.minute = 6'(mm);
    it.weekday_mask = mask;
    it.duration = 17'(secs);
    return it;
  endfunction

  function automatic in_t make_count(input int line, input int slots);
    in_t it;

    it = '0;
    it.cmd = CmdCount;
    it.line_sel = 3'(line);
    it.count_value = 3'(slots);
    return it;
  endfunction

  // Random item. Fields that the command does not use stay random. In a dense
  // phase most alarms share one time and most masks hold every day, so
  // ticks set off long runs of start events.
  function automatic in_t make_item(input bit dense);
    logic [95:0] noise;
    in_t         it;
    int          roll;
    int          pick;

    noise = {$urandom(), $urandom(), $urandom()};
    it = noise[$bits(in_t)-1:0];
    roll = $urandom_range(0, 99);
    pick = dense ? 0 : $urandom_range(0, 3);
    if (roll < 10) begin
      return it;
    end else if (roll < 14) begin
      it.cmd = CmdUnused;
    end else if (roll < 42) begin
      it.cmd = CmdEntry;
      if ($urandom_range(0, 9) != 0) begin
        it.hour = pool_hour[pick];
        it.minute = pool_minute[pick];
      end
      it.entry_enable = ($urandom_range(0, 4) != 0);
      if (dense && $urandom_range(0, 9) < 7) begin
        it.weekday_mask = 7'h7f;
      end
      case ($urandom_range(0, 5))
        0: it.duration = 17'd0;
        1: it.duration = 17'd86400;
        2: it.duration = 17'($urandom());
        default: it.duration = 17'($urandom_range(0, 86400));
      endcase
    end else if (roll < 52) begin
      it.cmd = CmdCount;
    end else if (have_tick && $urandom_range(0, 6) == 0) begin
      // Same minute key as the previous tick, with other fields changed.
      it = last_tick;
      it.year = 12'($urandom_range(2024, 4095));
      it.weekday = 3'($urandom_range(0, 7));
    end else begin
      it.cmd = CmdTick;
      case ($urandom_range(0, 9))
        0: it.year = 12'($urandom_range(0, 2023));
        1: begin
        end
        default: it.year = 12'($urandom_range(2024, 4095));
      endcase
      if ($urandom_range(0, 9) != 0) begin
        it.day_of_year = 9'($urandom_range(0, 365));
      end
      if ($urandom_range(0, 6) != 0) begin
        it.hour = pool_hour[pick];
        it.minute = pool_minute[pick];
      end
      it.weekday = 3'($urandom_range(0, 7));
    end
    if (it.cmd == CmdTick) begin
      last_tick = it;
      have_tick = 1'b1;
    end
    return it;
  endfunction

  // Sends one item in the current burst; a burst ends with a random gap.
  task automatic send_item(input in_t it);
    int gap;

    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    in_data <= it;
    valid_up = 1'b1;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        valid_up = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic write_lines(input int lines);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {RegActiveLines, 2'b00};
    pwdata <= 32'(lines);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Waits until every predicted start event has arrived and a scan without
  // matches would have finished too.
  task automatic drain();
    if (valid_up) begin
      in_valid <= 1'b0;
      valid_up = 1'b0;
    end
    @(posedge clk);
    while (events_pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  initial begin
    int   lines_setting;
    int   item_total;
    in_t  it;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_lines(8);
    send_item(make_count(0, 4));
    send_item(make_count(7, 7));
    send_item(make_count(2, 3));
    send_item(make_count(3, 0));
    send_item(make_entry(0, 0, 1'b1, 12, 30, 7'h7f, 86400));
    send_item(make_entry(0, 3, 1'b1, 12, 30, 7'h01, 0));
    send_item(make_entry(7, 3, 1'b1, 12, 30, 7'h40, 131071));
    send_item(make_entry(0, 1, 1'b0, 12, 30, 7'h7f, 5));
    send_item(make_entry(3, 0, 1'b1, 12, 30, 7'h7f, 77));
    send_item(make_entry(2, 2, 1'b1, 31, 63, 7'h7f, 1234));
    send_item(make_tick(2024, 0, 12, 30, 0));
    send_item(make_tick(2024, 0, 12, 30, 0));
    send_item(make_tick(2023, 1, 12, 30, 6));
    send_item(make_tick(4095, 1, 12, 30, 6));
    send_item(make_tick(2024, 2, 12, 30, 7));
    send_item(make_tick(2024, 2, 12, 30, 6));
    it = make_tick(2024, 3, 12, 30, 6);
    it.cmd = CmdUnused;
    send_item(it);
    send_item(make_tick(2024, 511, 31, 63, 3));
    send_item(make_tick(2024, 0, 0, 0, 0));
    send_item(make_tick(0, 0, 0, 0, 0));
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: lines_setting = 15;
        1: lines_setting = 0;
        2: lines_setting = 3;
        3: lines_setting = $urandom_range(1, 8);
        default: lines_setting = 8;
      endcase
      item_total = (phase == 1) ? 30 : 85;
      for (int p = 0; p < 4; p++) begin
        pool_hour[p] = 5'($urandom_range(0, 23));
        pool_minute[p] = 6'($urandom_range(0, 59));
      end
      write_lines(lines_setting);
      repeat (item_total) send_item(make_item(phase == 4));
      drain();
    end

    if (error_count == 0) begin
      $display("weekly_alarm_table_matcher_core_test: done, clean");
    end else begin
      $display("weekly_alarm_table_matcher_core_test: done, errors");
    end
    $finish;
  end

endmodule
